/* rtl/swas_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package swas_pkg;

  // Input operation codes (s_tuser)
  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_PATTERN = 2'd1;
  localparam logic [1:0] OP_TEXT    = 2'd2;

  // Field widths
  localparam int CHAR_W   = 7;
  localparam int OP_W     = 2;
  localparam int S_DATA_W = 8;
  localparam int LEN_W    = 11;
  localparam int M_DATA_W = 16;

  // Command kinds after classification
  typedef enum logic [1:0] {
    CMD_NOP = 2'd0,
    CMD_CLR = 2'd1,
    CMD_PAT = 2'd2,
    CMD_TXT = 2'd3
  } kind_t;

  // Queue entry between front and back
  typedef struct packed {
    kind_t             kind;
    logic [CHAR_W-1:0] chr;
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/swas_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module swas_front #(
  parameter int ALPHABET = 128
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               s_tvalid,
  output logic                              s_tready,
  input  wire  [swas_pkg::S_DATA_W-1:0]     s_tdata,
  input  wire  [swas_pkg::OP_W-1:0]         s_tuser,
  output logic                              q_valid,
  input  wire                               q_ready,
  output swas_pkg::cmd_t                    q_cmd
);

  localparam logic [8:0] ALPHA_LIM = 9'(ALPHABET);

  swas_pkg::cmd_t  cls_cmd;
  logic            in_range;
  swas_pkg::cmd_t  q_mem [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            push;
  logic            pop;

  // Classify the incoming transfer; out-of-alphabet characters become status-only
  assign in_range = ({2'b00, s_tdata[swas_pkg::CHAR_W-1:0]} < ALPHA_LIM);

  always_comb begin
    cls_cmd.chr = s_tdata[swas_pkg::CHAR_W-1:0];
    unique case (s_tuser)
      swas_pkg::OP_CLEAR:   cls_cmd.kind = swas_pkg::CMD_CLR;
      swas_pkg::OP_PATTERN: cls_cmd.kind = in_range ? swas_pkg::CMD_PAT : swas_pkg::CMD_NOP;
      swas_pkg::OP_TEXT:    cls_cmd.kind = in_range ? swas_pkg::CMD_TXT : swas_pkg::CMD_NOP;
      default:              cls_cmd.kind = swas_pkg::CMD_NOP;
    endcase
  end

  // Two-entry command queue
  assign s_tready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_cmd    = q_mem[rd_ptr];
  assign push     = s_tvalid && s_tready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= cls_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/swas_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module swas_back #(
  parameter int WINDOW_DEPTH = 1024,
  parameter int ALPHABET     = 128
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               q_valid,
  output logic                              q_ready,
  input  swas_pkg::cmd_t                    q_cmd,
  output logic                              m_tvalid,
  input  wire                               m_tready,
  output logic [swas_pkg::M_DATA_W-1:0]     m_tdata
);

  localparam int IDX_W  = $clog2(ALPHABET);
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int PTR_W  = $clog2(WINDOW_DEPTH);
  localparam int KIND_W = $clog2(ALPHABET + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(WINDOW_DEPTH);
  localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(WINDOW_DEPTH - 1);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_PAT_UPD  = 7'b0000010,
    S_TXT_UPD  = 7'b0000100,
    S_LEFT_RD  = 7'b0001000,
    S_LEFT_CH  = 7'b0010000,
    S_LEFT_CHK = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_t;

  function automatic logic [IDX_W-1:0] to_idx(input logic [swas_pkg::CHAR_W-1:0] c);
    logic [8:0] cx;
    cx = {2'b00, c};
    return cx[IDX_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p);
    return (p == LAST_P) ? '0 : p + PTR_W'(1);
  endfunction

  state_t                      state;
  logic [IDX_W-1:0]            cur_idx;
  logic [IDX_W-1:0]            q_idx;
  logic [IDX_W-1:0]            left_idx;
  logic [IDX_W-1:0]            rd_addr;

  // Count tables and the window ring
  logic [CNT_W-1:0]            pc_mem [ALPHABET];
  logic [CNT_W-1:0]            wc_mem [ALPHABET];
  logic [swas_pkg::CHAR_W-1:0] st_mem [WINDOW_DEPTH];
  logic [ALPHABET-1:0]         pc_vld;
  logic [ALPHABET-1:0]         wc_vld;
  logic [CNT_W-1:0]            pc_rd;
  logic [CNT_W-1:0]            wc_rd;
  logic                        pc_rd_ok;
  logic                        wc_rd_ok;
  logic [swas_pkg::CHAR_W-1:0] st_rd;
  logic [CNT_W-1:0]            pc_val;
  logic [CNT_W-1:0]            wc_val;

  // Write port controls
  logic                        pc_we;
  logic                        wc_we;
  logic [IDX_W-1:0]            wc_waddr;
  logic [CNT_W-1:0]            wc_wdata;
  logic                        st_we;

  // Scalar state
  logic [KIND_W-1:0]           pattern_kinds;
  logic [KIND_W-1:0]           present_kinds;
  logic [KIND_W-1:0]           supplied_kinds;
  logic [KIND_W-1:0]           present_next;
  logic [KIND_W-1:0]           supplied_next;
  logic [CNT_W-1:0]            pattern_length;
  logic [PTR_W-1:0]            left_pos;
  logic [PTR_W-1:0]            right_pos;
  logic [CNT_W-1:0]            fill;
  logic [CNT_W-1:0]            best;
  logic                        ovf;
  logic                        in_pat;
  logic                        drop;
  logic [31:0]                 best_w;

  assign q_ready  = (state == S_IDLE);
  assign q_idx    = to_idx(q_cmd.chr);
  assign left_idx = to_idx(st_rd);
  assign rd_addr  = (state == S_IDLE) ? q_idx : left_idx;
  assign pc_val   = pc_rd_ok ? pc_rd : '0;
  assign wc_val   = wc_rd_ok ? wc_rd : '0;
  assign in_pat   = (pc_val != '0);

  // Kind counts after adding the current text character
  assign present_next  = present_kinds + KIND_W'(in_pat && (wc_val == '0));
  assign supplied_next = supplied_kinds + KIND_W'(in_pat && (wc_val + CNT_W'(1) == pc_val));

  // Left edge may drop a character absent from the pattern or in surplus
  assign drop = !in_pat || (wc_val > pc_val);

  // Drive the table write ports
  always_comb begin
    pc_we    = (state == S_PAT_UPD);
    st_we    = (state == S_IDLE) && q_valid && (q_cmd.kind == swas_pkg::CMD_TXT) &&
               (fill != DEPTH_C);
    wc_we    = 1'b0;
    wc_waddr = cur_idx;
    wc_wdata = wc_val + CNT_W'(1);
    if (state == S_TXT_UPD) begin
      wc_we = in_pat;
    end else if (state == S_LEFT_CHK) begin
      wc_we    = in_pat && (wc_val > pc_val);
      wc_waddr = left_idx;
      wc_wdata = wc_val - CNT_W'(1);
    end
  end

  // Memory ports: one write and one registered read each
  always_ff @(posedge clk) begin
    if (pc_we) begin
      pc_mem[cur_idx] <= pc_val + CNT_W'(1);
    end
    if (wc_we) begin
      wc_mem[wc_waddr] <= wc_wdata;
    end
    if (st_we) begin
      st_mem[right_pos] <= q_cmd.chr;
    end
    pc_rd    <= pc_mem[rd_addr];
    wc_rd    <= wc_mem[rd_addr];
    pc_rd_ok <= pc_vld[rd_addr];
    wc_rd_ok <= wc_vld[rd_addr];
    st_rd    <= st_mem[left_pos];
  end

  assign best_w = 32'(best);

  // Sequencer and status registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      pc_vld         <= '0;
      wc_vld         <= '0;
      pattern_kinds  <= '0;
      present_kinds  <= '0;
      supplied_kinds <= '0;
      pattern_length <= '0;
      left_pos       <= '0;
      right_pos      <= '0;
      fill           <= '0;
      best           <= '0;
      ovf            <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      // Drop the result once it transfers, unless a new one is loaded
      if (m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur_idx <= q_idx;
            case (q_cmd.kind)
              swas_pkg::CMD_CLR: begin
                pc_vld         <= '0;
                wc_vld         <= '0;
                pattern_kinds  <= '0;
                present_kinds  <= '0;
                supplied_kinds <= '0;
                pattern_length <= '0;
                left_pos       <= '0;
                right_pos      <= '0;
                fill           <= '0;
                best           <= '0;
                ovf            <= 1'b0;
                state          <= S_DONE;
              end
              swas_pkg::CMD_PAT: begin
                if (pattern_length == DEPTH_C) begin
                  ovf   <= 1'b1;
                  state <= S_DONE;
                end else begin
                  // restart the text side
                  wc_vld         <= '0;
                  present_kinds  <= '0;
                  supplied_kinds <= '0;
                  left_pos       <= '0;
                  right_pos      <= '0;
                  fill           <= '0;
                  best           <= '0;
                  state          <= S_PAT_UPD;
                end
              end
              swas_pkg::CMD_TXT: begin
                if (fill == DEPTH_C) begin
                  ovf   <= 1'b1;
                  state <= S_DONE;
                end else begin
                  right_pos <= adv(right_pos);
                  fill      <= fill + CNT_W'(1);
                  state     <= S_TXT_UPD;
                end
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_PAT_UPD: begin
          pc_vld[cur_idx] <= 1'b1;
          if (pc_val == '0) begin
            pattern_kinds <= pattern_kinds + KIND_W'(1);
          end
          pattern_length <= pattern_length + CNT_W'(1);
          state          <= S_DONE;
        end
        S_TXT_UPD: begin
          if (in_pat) begin
            wc_vld[cur_idx] <= 1'b1;
          end
          present_kinds  <= present_next;
          supplied_kinds <= supplied_next;
          if ((present_next == pattern_kinds) && (supplied_next == pattern_kinds)) begin
            state <= S_LEFT_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_LEFT_RD: begin
          // store read at the left edge is issued this cycle
          if (fill == '0) begin
            if ((best == '0) || (best > fill)) begin
              best <= fill;
            end
            state <= S_DONE;
          end else begin
            state <= S_LEFT_CH;
          end
        end
        S_LEFT_CH: begin
          // count reads for the left character are issued this cycle
          state <= S_LEFT_CHK;
        end
        S_LEFT_CHK: begin
          if (drop) begin
            left_pos <= adv(left_pos);
            fill     <= fill - CNT_W'(1);
            state    <= S_LEFT_RD;
          end else begin
            if ((best == '0) || (best > fill)) begin
              best <= fill;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {{(swas_pkg::M_DATA_W - swas_pkg::LEN_W - 2){1'b0}}, ovf,
                         best_w[swas_pkg::LEN_W-1:0], (best == pattern_length)};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/sliding_window_anagram_search_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Fields (lowest bit up)
// s_*      in   tdata: character[6:0], pad; tuser: operation[1:0]
// m_*      out  tdata: found[0], shortest_cover[11:1], overflow[12], pad
//
// A text character updates the window counts in the back end; when the window
// covers the pattern, the left edge is then checked (unless the window is empty),
// and each character dropped at the left edge repeats that check; each step is one
// registered read or write on the count tables or the window ring.
// Pattern characters update the pattern counts; clear, ignored and overflowing items go straight to the result.
// The back end waits while the result register stays full.
// rst clears all counters and table valid bits.
// A two-entry queue keeps input accepted while the result register stalls, until the queue fills.

module sliding_window_anagram_search_unit #(
  parameter int WINDOW_DEPTH = 1024,
  parameter int ALPHABET     = 128
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               s_tvalid,
  output logic                              s_tready,
  input  wire  [swas_pkg::S_DATA_W-1:0]     s_tdata,  // character, pad
  input  wire  [swas_pkg::OP_W-1:0]         s_tuser,  // operation
  output logic                              m_tvalid,
  input  wire                               m_tready,
  output logic [swas_pkg::M_DATA_W-1:0]     m_tdata   // found, shortest_cover, overflow, pad
);

  logic            q_valid;
  logic            q_ready;
  swas_pkg::cmd_t  q_cmd;

  // Accept and classify
  swas_front #(
    .ALPHABET (ALPHABET)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_cmd    (q_cmd)
  );

  // Execute against the tables and the window
  swas_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .ALPHABET     (ALPHABET)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_cmd    (q_cmd),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire

/* tb/sliding_window_anagram_search_unit_tb.sv */
`timescale 1ns / 1ps

module sliding_window_anagram_search_unit_tb;

  localparam int RING_DEPTH  = 1024;
  localparam int CHARSET     = 128;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_ITEMS = 200;
  localparam int DRAIN_CYCLES = 20;
  // Operation code that the block must ignore
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic        found;
    logic [10:0] shortest_len;
    logic        ovf;
  } status_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [swas_pkg::S_DATA_W-1:0] s_tdata = '0;   // character[6:0], pad
  logic [swas_pkg::OP_W-1:0]     s_tuser = '0;   // operation[1:0]
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [swas_pkg::M_DATA_W-1:0] m_tdata;  // found[0], shortest_cover[11:1], overflow[12], pad

  sliding_window_anagram_search_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Search state mirrored on the testbench side
  int unsigned need_tally[CHARSET];
  int unsigned have_tally[CHARSET];
  int unsigned need_kinds;
  int unsigned seen_kinds;
  int unsigned met_kinds;
  int unsigned need_len;
  logic [6:0]  ring[RING_DEPTH];
  int unsigned head;
  int unsigned tail;
  int unsigned span;
  int unsigned shortest;
  bit          spill;

  status_t     status_due[$];
  status_t     got_status;
  status_t     want_status;
  int          errors = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  bit          calm = 1'b0;

  function automatic int unsigned ring_next(int unsigned p);
    return (p + 1 >= RING_DEPTH) ? 0 : p + 1;
  endfunction

  // Restart the text side: window tallies, edges and best length
  function void restart_window();
    foreach (have_tally[i]) have_tally[i] = 0;
    seen_kinds = 0;
    met_kinds  = 0;
    head       = 0;
    tail       = 0;
    span       = 0;
    shortest   = 0;
  endfunction

  function void clear_search();
    foreach (need_tally[i]) need_tally[i] = 0;
    need_kinds = 0;
    need_len   = 0;
    spill      = 1'b0;
    restart_window();
  endfunction

  function void add_pattern_char(logic [6:0] ch);
    if (need_len >= RING_DEPTH) begin
      spill = 1'b1;
      return;
    end
    restart_window();
    if (need_tally[ch] == 0) need_kinds++;
    need_tally[ch]++;
    need_len++;
  endfunction

  function void add_text_char(logic [6:0] ch);
    logic [6:0] lead;
    if (span >= RING_DEPTH) begin
      spill = 1'b1;
      return;
    end
    ring[head] = ch;
    head = ring_next(head);
    span++;
    if (need_tally[ch] != 0) begin
      if (have_tally[ch] == 0) seen_kinds++;
      have_tally[ch]++;
      if (have_tally[ch] == need_tally[ch]) met_kinds++;
    end
    if (seen_kinds == need_kinds && met_kinds == need_kinds) begin
      // shrink the left edge past foreign and surplus characters
      while (span > 0) begin
        lead = ring[tail];
        if (need_tally[lead] == 0) begin
        end else if (have_tally[lead] > need_tally[lead]) begin
          have_tally[lead]--;
        end else begin
          break;
        end
        tail = ring_next(tail);
        span--;
      end
      if (shortest == 0 || shortest > span) shortest = span;
    end
  endfunction

  function status_t predict_status(logic [1:0] op, logic [6:0] ch);
    status_t st;
    case (op)
      swas_pkg::OP_CLEAR:   clear_search();
      swas_pkg::OP_PATTERN: add_pattern_char(ch);
      swas_pkg::OP_TEXT:    add_text_char(ch);
      default: begin
      end
    endcase
    st.found        = (shortest == need_len);
    st.shortest_len = shortest[10:0];
    st.ovf          = spill;
    return st;
  endfunction

  // Drive one item and record its expected status once it transfers
  task automatic send_item(input logic [1:0] op, input logic [6:0] ch);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, ch};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    status_due.push_back(predict_status(op, ch));
    items_sent++;
    @(negedge clk);
  endtask

  // Hold the input idle until every expected status has come back
  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (status_due.size() != 0);
  endtask

  function automatic logic [6:0] pick_char(int unsigned base, int unsigned span_sz);
    return 7'(base + $urandom_range(0, span_sz - 1));
  endfunction

  task automatic test_directed();
    send_item(swas_pkg::OP_CLEAR, 7'h00);
    // empty pattern: every window covers, found stays high
    send_item(swas_pkg::OP_TEXT, 7'h7f);
    send_item(swas_pkg::OP_TEXT, 7'h00);
    send_item(OP_UNUSED, 7'h55);
    // pattern {0, 127, 0}
    send_item(swas_pkg::OP_PATTERN, 7'h00);
    send_item(swas_pkg::OP_PATTERN, 7'h7f);
    send_item(swas_pkg::OP_PATTERN, 7'h00);
    send_item(swas_pkg::OP_TEXT, 7'h7f);
    send_item(swas_pkg::OP_TEXT, 7'h78);
    send_item(swas_pkg::OP_TEXT, 7'h00);
    send_item(swas_pkg::OP_TEXT, 7'h00);
    // surplus and foreign characters drop off the left edge
    send_item(swas_pkg::OP_TEXT, 7'h7f);
    send_item(OP_UNUSED, 7'h2a);
    // pattern character after text restarts the window
    send_item(swas_pkg::OP_PATTERN, 7'h61);
    send_item(swas_pkg::OP_TEXT, 7'h61);
    send_item(swas_pkg::OP_TEXT, 7'h00);
    send_item(swas_pkg::OP_TEXT, 7'h7f);
    send_item(swas_pkg::OP_TEXT, 7'h61);
    send_item(swas_pkg::OP_TEXT, 7'h00);
    send_item(swas_pkg::OP_CLEAR, 7'h7f);
    send_item(swas_pkg::OP_TEXT, 7'h31);
  endtask

  task automatic test_pattern_overflow();
    send_item(swas_pkg::OP_CLEAR, 7'h00);
    repeat (RING_DEPTH + 1) send_item(swas_pkg::OP_PATTERN, 7'($urandom_range(0, 127)));
    repeat (5) send_item(swas_pkg::OP_TEXT, 7'($urandom_range(0, 127)));
    send_item(swas_pkg::OP_PATTERN, 7'h41);
    send_item(OP_UNUSED, 7'h00);
    // clear drops the overflow flag too
    send_item(swas_pkg::OP_CLEAR, 7'h00);
    send_item(swas_pkg::OP_TEXT, 7'h41);
  endtask

  task automatic test_window_overflow();
    logic [6:0] ch;
    send_item(swas_pkg::OP_CLEAR, 7'h00);
    send_item(swas_pkg::OP_PATTERN, 7'h5a);
    // fill the window with characters that never cover the pattern
    repeat (RING_DEPTH + 2) begin
      ch = 7'($urandom_range(0, 126));
      if (ch >= 7'h5a) ch = ch + 7'd1;
      send_item(swas_pkg::OP_TEXT, ch);
    end
    send_item(swas_pkg::OP_TEXT, 7'h5a);
    send_item(swas_pkg::OP_PATTERN, 7'h5a);
    send_item(swas_pkg::OP_TEXT, 7'h5a);
    send_item(swas_pkg::OP_TEXT, 7'h5a);
    send_item(swas_pkg::OP_CLEAR, 7'h00);
  endtask

  task automatic test_random();
    int unsigned stop_at;
    int unsigned kind;
    int unsigned base;
    int unsigned sz;
    int unsigned plen;
    int unsigned tlen;
    int unsigned j;
    logic [6:0]  pat[6];
    logic [6:0]  tmp;
    stop_at = items_sent + RANDOM_ITEMS;
    hold_until_drained();
    while (items_sent < stop_at) begin
      kind = $urandom_range(0, 9);
      calm = ($urandom_range(0, 5) == 0);
      if (kind <= 6) begin
        if ($urandom_range(0, 9) < 7) begin
          send_item(swas_pkg::OP_CLEAR, 7'($urandom_range(0, 127)));
        end
        base = $urandom_range(0, 124);
        sz   = $urandom_range(1, 4);
        plen = $urandom_range(1, 6);
        for (int i = 0; i < plen; i++) begin
          pat[i] = pick_char(base, sz);
          send_item(swas_pkg::OP_PATTERN, pat[i]);
        end
        tlen = $urandom_range(5, 40);
        for (int i = 0; i < tlen; i++) begin
          if ($urandom_range(0, 7) == 0) begin
            // plant an anagram of the pattern
            for (int k = plen - 1; k > 0; k--) begin
              j = $urandom_range(0, k);
              tmp = pat[k];
              pat[k] = pat[j];
              pat[j] = tmp;
            end
            for (int k = 0; k < plen; k++) send_item(swas_pkg::OP_TEXT, pat[k]);
          end else if ($urandom_range(0, 9) < 7) begin
            send_item(swas_pkg::OP_TEXT, pick_char(base, sz));
          end else begin
            send_item(swas_pkg::OP_TEXT, 7'($urandom_range(0, 127)));
          end
        end
      end else if (kind <= 8) begin
        repeat ($urandom_range(1, 5))
          send_item(2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)));
      end else begin
        hold_until_drained();
      end
    end
    calm = 1'b0;
  endtask

  // Result side: unless calm, stall at random before each transfer
  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!calm) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  // Compare each result transfer with the oldest expected status
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_status.found        = m_tdata[0];
      got_status.shortest_len = m_tdata[11:1];
      got_status.ovf          = m_tdata[12];
      if (status_due.size() == 0) begin
        $error("unexpected result transfer: m_tdata=%h", m_tdata);
        errors++;
      end else begin
        want_status = status_due.pop_front();
        if (got_status.found !== want_status.found) begin
          $error("found: expected %0d, got %0d", want_status.found, got_status.found);
          errors++;
        end
        if (got_status.shortest_len !== want_status.shortest_len) begin
          $error("shortest_cover: expected %0d, got %0d",
                 want_status.shortest_len, got_status.shortest_len);
          errors++;
        end
        if (got_status.ovf !== want_status.ovf) begin
          $error("overflow: expected %0d, got %0d", want_status.ovf, got_status.ovf);
          errors++;
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("sliding_window_anagram_search_unit_tb failed");
      $finish;
    end
  end

  initial begin
    clear_search();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_pattern_overflow();
    test_window_overflow();
    test_random();
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (status_due.size() != 0) begin
      $error("%0d expected results never arrived", status_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("sliding_window_anagram_search_unit_tb passed");
    end else begin
      $display("sliding_window_anagram_search_unit_tb failed");
    end
    $finish;
  end

endmodule
